// File: rtl/pvkt_pkg.sv
// ----------------------------------------------------------------------------
// pvkt_pkg
// Shared types, constants and saturation helpers for the 3D tracker.
// ----------------------------------------------------------------------------
package pvkt_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64 - FRAC_BITS + 4;
    localparam int NS        = 6;
    localparam int COV_N     = NS * NS;
    localparam int COV_AW    = $clog2(2 * COV_N);
    localparam int K_N       = NS * 3;
    localparam int K_AW      = $clog2(K_N);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 31;
    localparam int DIV_STEPS = (DATA_W + FRAC_BITS + 1) / 2;
    localparam int QUO_W     = 2 * DIV_STEPS;

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;
    localparam word_t ONE      = word_t'(64'sd1 <<< FRAC_BITS);
    localparam word_t HALF     = word_t'(64'sd1 <<< (FRAC_BITS - 1));
    localparam word_t QUARTER  = word_t'(64'sd1 <<< (FRAC_BITS - 2));

    localparam logic [CFG_W-1:0] INIT_VAR = CFG_W'(64'd1 << FRAC_BITS);

    typedef enum logic [1:0] {
        CMD_RESTART = 2'd0,
        CMD_PREDICT = 2'd1,
        CMD_UPDATE  = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_POS_VAR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR = CFG_IDX_W'(1);

    function automatic word_t sat_word(input acc_t v);
        if (v > acc_t'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < acc_t'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return word_t'(v);
    endfunction

    function automatic word_t add_sat(input word_t a, input word_t b);
        return sat_word(acc_t'(a) + acc_t'(b));
    endfunction

    function automatic logic [DATA_W-1:0] mag(input word_t v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// File: rtl/position_velocity_kalman_tracker.sv
// ----------------------------------------------------------------------------
// position_velocity_kalman_tracker
// Six-state constant-velocity tracker: restart, predict and update commands
// run on one shared multiplier and one radix-4 divider under a sequencer.
// ----------------------------------------------------------------------------
//  channel   | ports                          | role
//  ----------+--------------------------------+-------------------------------
//  s_        | s_valid/s_ready, s_cmd, ...    | command transfer in
//  m_        | m_valid/m_ready, m_pos_*, ...  | estimate transfer out
//  cfg_      | cfg_valid/cfg_ready, index/data| register write
//
//  Restart: 36-entry covariance sweep. Predict: fifteen multiplies.
//  Update: 18 divides and 126 multiply-accumulates (a zero divisor
//  skips its divide).
//  After reset a 36-entry covariance sweep runs with s_ready low.
//  s_ready is high only while the sequencer is idle; a finished estimate
//  waits in the output register, and the next command is taken meanwhile.
module position_velocity_kalman_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_cmd,
    input  pvkt_pkg::word_t                 s_accel_x,
    input  pvkt_pkg::word_t                 s_accel_y,
    input  pvkt_pkg::word_t                 s_accel_z,
    input  logic [16:0]                     s_step_time,
    input  pvkt_pkg::word_t                 s_meas_x,
    input  pvkt_pkg::word_t                 s_meas_y,
    input  pvkt_pkg::word_t                 s_meas_z,
    output logic                            m_valid,
    input  logic                            m_ready,
    output pvkt_pkg::word_t                 m_pos_x,
    output pvkt_pkg::word_t                 m_pos_y,
    output pvkt_pkg::word_t                 m_pos_z,
    output pvkt_pkg::word_t                 m_vel_x,
    output pvkt_pkg::word_t                 m_vel_y,
    output pvkt_pkg::word_t                 m_vel_z,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pvkt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data
);
    import pvkt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RST, S_MUL, S_ACC, S_DONE,
        P_DT2, P_D4, P_Q, P_QW, P_HA, P_HAW, P_DP2, P_DPW, P_DVW, P_CRD, P_CWR,
        U_Y, U_S, U_KRD, U_KDIV, U_KITER, U_KW, U_ERD, U_EMUL, U_EW,
        U_PRD, U_PINIT, U_PRDK, U_PMUL, U_PW
    } state_t;

    state_t            state_reg, ret_reg;
    logic              boot_reg, bank_reg, sub_reg;
    logic [2:0]        i_reg, j_reg;
    logic [1:0]        m_reg;
    word_t             accel_reg [3];
    word_t             meas_reg  [3];
    logic [16:0]       dt_reg;
    word_t             est_reg   [NS];
    word_t             y_reg     [3];
    word_t             s_reg     [3];
    word_t             t_reg, q_reg, h_reg;
    word_t             mul_a_reg, mul_b_reg;
    logic signed [63:0] prod_reg;
    acc_t              acc_reg;
    logic [CFG_W-1:0]  pos_var_reg, mv_reg;

    // divider
    word_t               div_a_reg;
    logic [DATA_W-1:0]   div_den_reg;
    logic [QUO_W-1:0]    div_num_reg, div_quo_reg;
    logic [DATA_W:0]     div_rem_reg;
    logic [$clog2(DIV_STEPS)-1:0] div_cnt_reg;
    logic                div_neg_reg;

    // memories
    word_t             cov_mem [2*COV_N];
    word_t             k_mem   [K_N];
    word_t             cov_rd_reg, k_rd_reg;

    logic              cov_we, k_we;
    logic [COV_AW-1:0] cov_wa, cov_ra;
    word_t             cov_wd;
    logic [K_AW-1:0]   k_wa, k_ra;
    word_t             k_wd;
    logic [2:0]        est_ra;
    word_t             est_rd;
    word_t             sweep_val;
    word_t             div_res;
    acc_t              term;
    logic [DATA_W:0]   div_rem_n;
    logic [QUO_W-1:0]  div_num_n, div_quo_n;
    logic              last_j6, last_j3;

    function automatic logic [COV_AW-1:0] cov_addr(input logic b, input logic [2:0] r,
                                                    input logic [2:0] c);
        logic [COV_AW-1:0] base;
        base = b ? COV_AW'(COV_N) : '0;
        return base + COV_AW'(r) * COV_AW'(NS) + COV_AW'(c);
    endfunction

    function automatic logic [K_AW-1:0] k_addr(input logic [2:0] r, input logic [1:0] c);
        return K_AW'(r) * K_AW'(3) + K_AW'(c);
    endfunction

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign est_rd    = est_reg[est_ra];
    assign term      = acc_t'(prod_reg >>> FRAC_BITS);   // floor of the product
    assign last_j6   = (j_reg == 3'(NS - 1));
    assign last_j3   = (j_reg == 3'd2);

    // Restart value: position diagonal gets the configured variance (reset value
    // during the power-up sweep), velocity diagonal gets one.
    always_comb begin
        if (i_reg != j_reg) begin
            sweep_val = '0;
        end else if (i_reg < 3'd3) begin
            sweep_val = word_t'({1'b0, (boot_reg ? INIT_VAR : pos_var_reg)});
        end else begin
            sweep_val = ONE;
        end
    end

    // Two restoring steps a cycle on the magnitudes.
    always_comb begin
        logic [DATA_W:0]  r;
        logic [QUO_W-1:0] n;
        logic [QUO_W-1:0] q;
        r = div_rem_reg;
        n = div_num_reg;
        q = div_quo_reg;
        for (int k = 0; k < 2; k++) begin
            r = {r[DATA_W-1:0], n[QUO_W-1]};
            n = n << 1;
            if (r >= {1'b0, div_den_reg}) begin
                r = r - {1'b0, div_den_reg};
                q = {q[QUO_W-2:0], 1'b1};
            end else begin
                q = {q[QUO_W-2:0], 1'b0};
            end
        end
        div_rem_n = r;
        div_num_n = n;
        div_quo_n = q;
    end

    // Signed, saturated quotient; a zero divisor saturates by dividend sign.
    always_comb begin
        if (s_reg[j_reg[1:0]] == '0) begin
            if (div_a_reg > 0) begin
                div_res = WORD_MAX;
            end else if (div_a_reg < 0) begin
                div_res = WORD_MIN;
            end else begin
                div_res = '0;
            end
        end else if (div_neg_reg) begin
            if (div_quo_reg > QUO_W'(64'h8000_0000)) begin
                div_res = WORD_MIN;
            end else begin
                div_res = word_t'(~div_quo_reg[DATA_W-1:0] + 1'b1);
            end
        end else if (div_quo_reg > QUO_W'(64'h7FFF_FFFF)) begin
            div_res = WORD_MAX;
        end else begin
            div_res = word_t'(div_quo_reg[DATA_W-1:0]);
        end
    end

    // Memory and estimate port control per state.
    always_comb begin
        cov_we = 1'b0;
        cov_wa = cov_addr(bank_reg, i_reg, j_reg);
        cov_wd = sweep_val;
        cov_ra = cov_addr(bank_reg, i_reg, j_reg);
        k_we   = 1'b0;
        k_wa   = k_addr(i_reg, j_reg[1:0]);
        k_wd   = div_res;
        k_ra   = k_addr(i_reg, m_reg);
        est_ra = i_reg;
        case (state_reg)
            S_RST: begin
                cov_we = 1'b1;
            end
            P_HAW, P_DVW: begin
                est_ra = 3'(i_reg + 3'd3);
            end
            P_CRD: begin
                cov_ra = cov_addr(bank_reg, i_reg, i_reg);
            end
            P_CWR: begin
                cov_we = 1'b1;
                cov_wa = cov_addr(bank_reg, i_reg, i_reg);
                cov_wd = add_sat(cov_rd_reg, (i_reg < 3'd3) ? q_reg : t_reg);
            end
            U_Y: begin
                cov_ra = cov_addr(bank_reg, i_reg, i_reg);
            end
            U_KW: begin
                k_we = 1'b1;
            end
            U_PRDK: begin
                cov_ra = cov_addr(bank_reg, {1'b0, m_reg}, j_reg);
            end
            U_PW: begin
                cov_we = 1'b1;
                cov_wa = cov_addr(!bank_reg, i_reg, j_reg);
                cov_wd = sat_word(acc_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cov_we) begin
            cov_mem[cov_wa] <= cov_wd;
        end
        cov_rd_reg <= cov_mem[cov_ra];
    end

    always_ff @(posedge aclk) begin
        if (k_we) begin
            k_mem[k_wa] <= k_wd;
        end
        k_rd_reg <= k_mem[k_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RST;
            ret_reg     <= S_IDLE;
            boot_reg    <= 1'b1;
            bank_reg    <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            m_reg       <= '0;
            m_valid     <= 1'b0;
            pos_var_reg <= INIT_VAR;
            mv_reg      <= INIT_VAR;
            for (int e = 0; e < NS; e++) begin
                est_reg[e] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_POS_VAR) begin
                    pos_var_reg <= cfg_data[CFG_W-1:0];
                end else if (cfg_index == REG_MEAS_VAR) begin
                    mv_reg <= cfg_data[CFG_W-1:0];
                end
            end
            // S_DONE reloads the output register itself
            if (m_valid && m_ready && (state_reg != S_DONE)) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        accel_reg[0] <= s_accel_x;
                        accel_reg[1] <= s_accel_y;
                        accel_reg[2] <= s_accel_z;
                        meas_reg[0]  <= s_meas_x;
                        meas_reg[1]  <= s_meas_y;
                        meas_reg[2]  <= s_meas_z;
                        dt_reg       <= s_step_time;
                        i_reg        <= '0;
                        j_reg        <= '0;
                        m_reg        <= '0;
                        case (s_cmd)
                            CMD_RESTART: begin
                                for (int e = 0; e < NS; e++) begin
                                    est_reg[e] <= '0;
                                end
                                state_reg <= S_RST;
                            end
                            CMD_PREDICT: state_reg <= P_DT2;
                            CMD_UPDATE:  state_reg <= U_Y;
                            default:     state_reg <= S_DONE;   // unused code: no change
                        endcase
                    end
                end
                S_RST: begin
                    if (last_j6) begin
                        j_reg <= '0;
                        if (i_reg == 3'(NS - 1)) begin
                            i_reg     <= '0;
                            boot_reg  <= 1'b0;
                            state_reg <= boot_reg ? S_IDLE : S_DONE;
                        end else begin
                            i_reg <= i_reg + 3'd1;
                        end
                    end else begin
                        j_reg <= j_reg + 3'd1;
                    end
                end
                S_MUL: begin
                    prod_reg  <= mul_a_reg * mul_b_reg;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg   <= sub_reg ? (acc_reg - term) : (acc_reg + term);
                    state_reg <= ret_reg;
                end
                // ---------------- predict ----------------
                P_DT2: begin
                    mul_a_reg <= word_t'(dt_reg);
                    mul_b_reg <= word_t'(dt_reg);
                    acc_reg   <= '0;
                    sub_reg   <= 1'b0;
                    ret_reg   <= P_D4;
                    state_reg <= S_MUL;
                end
                P_D4: begin
                    t_reg     <= sat_word(acc_reg);
                    mul_a_reg <= sat_word(acc_reg);
                    mul_b_reg <= sat_word(acc_reg);
                    acc_reg   <= '0;
                    ret_reg   <= P_Q;
                    state_reg <= S_MUL;
                end
                P_Q: begin
                    mul_a_reg <= QUARTER;
                    mul_b_reg <= sat_word(acc_reg);
                    acc_reg   <= '0;
                    ret_reg   <= P_QW;
                    state_reg <= S_MUL;
                end
                P_QW: begin
                    q_reg     <= sat_word(acc_reg);
                    i_reg     <= '0;
                    state_reg <= P_HA;
                end
                P_HA: begin
                    mul_a_reg <= HALF;
                    mul_b_reg <= accel_reg[i_reg[1:0]];
                    acc_reg   <= '0;
                    ret_reg   <= P_HAW;
                    state_reg <= S_MUL;
                end
                P_HAW: begin
                    h_reg     <= sat_word(acc_reg);
                    mul_a_reg <= est_rd;                 // old velocity
                    mul_b_reg <= word_t'(dt_reg);
                    acc_reg   <= '0;
                    ret_reg   <= P_DP2;
                    state_reg <= S_MUL;
                end
                P_DP2: begin
                    mul_a_reg <= h_reg;
                    mul_b_reg <= t_reg;
                    ret_reg   <= P_DPW;
                    state_reg <= S_MUL;
                end
                P_DPW: begin
                    est_reg[i_reg] <= add_sat(est_rd, sat_word(acc_reg));
                    mul_a_reg      <= accel_reg[i_reg[1:0]];
                    mul_b_reg      <= word_t'(dt_reg);
                    acc_reg        <= '0;
                    ret_reg        <= P_DVW;
                    state_reg      <= S_MUL;
                end
                P_DVW: begin
                    est_reg[3'(i_reg + 3'd3)] <= add_sat(est_rd, sat_word(acc_reg));
                    if (i_reg == 3'd2) begin
                        i_reg     <= '0;
                        state_reg <= P_CRD;
                    end else begin
                        i_reg     <= i_reg + 3'd1;
                        state_reg <= P_HA;
                    end
                end
                P_CRD: begin
                    state_reg <= P_CWR;
                end
                P_CWR: begin
                    if (i_reg == 3'(NS - 1)) begin
                        i_reg     <= '0;
                        state_reg <= S_DONE;
                    end else begin
                        i_reg     <= i_reg + 3'd1;
                        state_reg <= P_CRD;
                    end
                end
                // ---------------- update ----------------
                U_Y: begin
                    y_reg[i_reg[1:0]] <= sat_word(acc_t'(meas_reg[i_reg[1:0]]) - acc_t'(est_rd));
                    state_reg         <= U_S;
                end
                U_S: begin
                    s_reg[i_reg[1:0]] <= add_sat(cov_rd_reg, word_t'({1'b0, mv_reg}));
                    if (i_reg == 3'd2) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= U_KRD;
                    end else begin
                        i_reg     <= i_reg + 3'd1;
                        state_reg <= U_Y;
                    end
                end
                U_KRD: begin
                    state_reg <= U_KDIV;
                end
                U_KDIV: begin
                    div_a_reg   <= cov_rd_reg;
                    div_den_reg <= mag(s_reg[j_reg[1:0]]);
                    div_num_reg <= QUO_W'(mag(cov_rd_reg)) << FRAC_BITS;
                    div_quo_reg <= '0;
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                    div_neg_reg <= cov_rd_reg[DATA_W-1] ^ s_reg[j_reg[1:0]][DATA_W-1];
                    state_reg   <= (s_reg[j_reg[1:0]] == '0) ? U_KW : U_KITER;
                end
                U_KITER: begin
                    div_rem_reg <= div_rem_n;
                    div_num_reg <= div_num_n;
                    div_quo_reg <= div_quo_n;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == ($bits(div_cnt_reg))'(DIV_STEPS - 1)) begin
                        state_reg <= U_KW;
                    end
                end
                U_KW: begin
                    if (last_j3) begin
                        j_reg <= '0;
                        if (i_reg == 3'(NS - 1)) begin
                            i_reg     <= '0;
                            m_reg     <= '0;
                            state_reg <= U_ERD;
                        end else begin
                            i_reg     <= i_reg + 3'd1;
                            state_reg <= U_KRD;
                        end
                    end else begin
                        j_reg     <= j_reg + 3'd1;
                        state_reg <= U_KRD;
                    end
                end
                U_ERD: begin
                    if (m_reg == 2'd0) begin
                        acc_reg <= '0;
                    end
                    state_reg <= U_EMUL;
                end
                U_EMUL: begin
                    mul_a_reg <= k_rd_reg;
                    mul_b_reg <= y_reg[m_reg];
                    sub_reg   <= 1'b0;
                    ret_reg   <= (m_reg == 2'd2) ? U_EW : U_ERD;
                    m_reg     <= (m_reg == 2'd2) ? 2'd0 : m_reg + 2'd1;
                    state_reg <= S_MUL;
                end
                U_EW: begin
                    est_reg[i_reg] <= add_sat(est_rd, sat_word(acc_reg));
                    if (i_reg == 3'(NS - 1)) begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= U_PRD;
                    end else begin
                        i_reg     <= i_reg + 3'd1;
                        state_reg <= U_ERD;
                    end
                end
                U_PRD: begin
                    state_reg <= U_PINIT;
                end
                U_PINIT: begin
                    acc_reg   <= acc_t'(cov_rd_reg);
                    state_reg <= U_PRDK;
                end
                U_PRDK: begin
                    state_reg <= U_PMUL;
                end
                U_PMUL: begin
                    mul_a_reg <= k_rd_reg;
                    mul_b_reg <= cov_rd_reg;
                    sub_reg   <= 1'b1;
                    ret_reg   <= (m_reg == 2'd2) ? U_PW : U_PRDK;
                    m_reg     <= (m_reg == 2'd2) ? 2'd0 : m_reg + 2'd1;
                    state_reg <= S_MUL;
                end
                U_PW: begin
                    // new covariance goes to the other bank; old one stays readable
                    if (last_j6) begin
                        j_reg <= '0;
                        if (i_reg == 3'(NS - 1)) begin
                            i_reg     <= '0;
                            bank_reg  <= !bank_reg;
                            state_reg <= S_DONE;
                        end else begin
                            i_reg     <= i_reg + 3'd1;
                            state_reg <= U_PRD;
                        end
                    end else begin
                        j_reg     <= j_reg + 3'd1;
                        state_reg <= U_PRD;
                    end
                end
                S_DONE: begin
                    if (!m_valid || m_ready) begin
                        m_valid   <= 1'b1;
                        m_pos_x   <= est_reg[0];
                        m_pos_y   <= est_reg[1];
                        m_pos_z   <= est_reg[2];
                        m_vel_x   <= est_reg[3];
                        m_vel_y   <= est_reg[4];
                        m_vel_z   <= est_reg[5];
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_per_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken on consecutive cycles");

    a_bank_flip: assert property (@(posedge aclk) disable iff (!aresetn)
        (bank_reg != $past(bank_reg)) |-> ($past(state_reg) == U_PW))
        else $error("covariance bank flipped outside update write-back");

    a_row_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (i_reg < 3'(NS)) && (j_reg < 3'(NS)))
        else $error("row or column counter out of range");

    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == U_KITER) |-> (div_cnt_reg < ($bits(div_cnt_reg))'(DIV_STEPS)))
        else $error("divider step count overrun");

    a_boot_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        boot_reg |-> (!m_valid && !s_ready))
        else $error("activity during power-up sweep");
`endif

endmodule

// File: tb/sv/tb_position_velocity_kalman_tracker.sv
// ----------------------------------------------------------------------------
// tb_position_velocity_kalman_tracker
// Self-checking bench for the six-state tracker: drives restart, predict,
// update and unused commands over valid/ready, writes both variance
// registers between phases, and checks every estimate transfer against
// a fixed-point tracker model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_position_velocity_kalman_tracker;
    timeunit 1ns;
    timeprecision 1ps;
    import pvkt_pkg::*;

    // unused command code: the block must echo the estimate untouched
    localparam logic [1:0] CMD_IDLE_CODE = 2'd3;
    // register indexes past the end of the list, writes must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_NONE_B = CFG_IDX_W'(3);
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int     DRAIN_WAIT  = 1500;   // longer than one update
    localparam int     HOLD_CYCLES = 3000;

    typedef struct {
        word_t pos[3];
        word_t vel[3];
    } estimate_t;

    // ------------------------------------------------------------------
    // Tracker scoreboard: its own estimate, covariance and registers,
    // plus the queue of estimates the block still owes us.
    // ------------------------------------------------------------------
    class tracker_scoreboard;
        longint    est[6];
        longint    cov[6][6];
        longint    pos_var;
        longint    meas_var;
        estimate_t pending[$];
        int        errors;

        function new();
            pos_var  = longint'(1) << FRAC_BITS;
            meas_var = longint'(1) << FRAC_BITS;
            errors   = 0;
            restart();
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // floor shift equals arithmetic shift on two's complement
        function longint fmul(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> FRAC_BITS;
        endfunction

        function longint fdiv(longint a, longint b);
            if (b == 0) begin
                if (a > 0) return 64'sd2147483647;
                if (a < 0) return -64'sd2147483648;
                return 0;
            end
            return sat32((a * (longint'(1) << FRAC_BITS)) / b);
        endfunction

        function void restart();
            for (int i = 0; i < 6; i++) begin
                est[i] = 0;
                for (int j = 0; j < 6; j++) cov[i][j] = 0;
            end
            for (int i = 0; i < 3; i++) begin
                cov[i][i]     = pos_var;
                cov[i+3][i+3] = longint'(1) << FRAC_BITS;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == REG_POS_VAR) pos_var = longint'(data[30:0]);
            else if (idx == REG_MEAS_VAR) meas_var = longint'(data[30:0]);
        endfunction

        function void predict(longint acc[3], longint dt);
            longint dt2, qpos, ha, dp;
            dt2  = sat32(fmul(dt, dt));
            qpos = sat32(fmul(longint'(QUARTER), sat32(fmul(dt2, dt2))));
            for (int i = 0; i < 3; i++) begin
                ha       = sat32(fmul(longint'(HALF), acc[i]));
                dp       = sat32(fmul(est[i+3], dt) + fmul(ha, dt2));
                est[i]   = sat32(est[i] + dp);
                est[i+3] = sat32(est[i+3] + sat32(fmul(acc[i], dt)));
            end
            for (int i = 0; i < 3; i++) begin
                cov[i][i]     = sat32(cov[i][i] + qpos);
                cov[i+3][i+3] = sat32(cov[i+3][i+3] + dt2);
            end
        endfunction

        function void correct(longint z[3]);
            longint innov[3], s[3], gain[6][3], pn[6][6], sum;
            for (int j = 0; j < 3; j++) begin
                innov[j] = sat32(z[j] - est[j]);
                s[j]     = sat32(cov[j][j] + meas_var);
            end
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 3; j++) gain[i][j] = fdiv(cov[i][j], s[j]);
            for (int i = 0; i < 6; i++) begin
                sum = 0;
                for (int j = 0; j < 3; j++) sum += fmul(gain[i][j], innov[j]);
                est[i] = sat32(est[i] + sat32(sum));
            end
            for (int i = 0; i < 6; i++)
                for (int j = 0; j < 6; j++) begin
                    sum = cov[i][j];
                    for (int m = 0; m < 3; m++) sum -= fmul(gain[i][m], cov[m][j]);
                    pn[i][j] = sat32(sum);
                end
            cov = pn;
        endfunction

        // accepted command: advance the model and queue the estimate
        function void note_command(logic [1:0] cmd, word_t acc[3], logic [16:0] dt,
                                   word_t meas[3]);
            longint a[3], z[3];
            estimate_t e;
            for (int i = 0; i < 3; i++) begin
                a[i] = longint'(acc[i]);
                z[i] = longint'(meas[i]);
            end
            case (cmd)
                CMD_RESTART: restart();
                CMD_PREDICT: predict(a, longint'(dt));
                CMD_UPDATE:  correct(z);
                default: ;
            endcase
            for (int i = 0; i < 3; i++) begin
                e.pos[i] = word_t'(est[i]);
                e.vel[i] = word_t'(est[i+3]);
            end
            pending.push_back(e);
        endfunction

        function void check_result(estimate_t got);
            estimate_t want;
            if (pending.size() == 0) begin
                $display("%0t: estimate transfer with none expected", $realtime);
                errors++;
                return;
            end
            want = pending.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.pos[i] !== want.pos[i]) begin
                    $display("%0t: pos[%0d] expected %h actual %h", $realtime, i,
                             want.pos[i], got.pos[i]);
                    errors++;
                end
                if (got.vel[i] !== want.vel[i]) begin
                    $display("%0t: vel[%0d] expected %h actual %h", $realtime, i,
                             want.vel[i], got.vel[i]);
                    errors++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #4 aclk = ~aclk;

    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_cmd = '0;
    word_t             s_accel_x = '0, s_accel_y = '0, s_accel_z = '0;
    logic [16:0]       s_step_time = '0;
    word_t             s_meas_x = '0, s_meas_y = '0, s_meas_z = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    word_t             m_pos_x, m_pos_y, m_pos_z, m_vel_x, m_vel_y, m_vel_z;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]       cfg_data = '0;

    position_velocity_kalman_tracker dut (.*);

    tracker_scoreboard sb = new();

    bit     quiet;          // last part of the run: no idling on either side
    bit     hold_request;   // ask the receiver for one long hold-off
    longint cycles;

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled on the same edge the block sees
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        word_t acc[3], meas[3];
        estimate_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                acc  = '{s_accel_x, s_accel_y, s_accel_z};
                meas = '{s_meas_x, s_meas_y, s_meas_z};
                sb.note_command(s_cmd, acc, s_step_time, meas);
            end
            if (m_valid && m_ready) begin
                got.pos = '{m_pos_x, m_pos_y, m_pos_z};
                got.vel = '{m_vel_x, m_vel_y, m_vel_z};
                sb.check_result(got);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_position_velocity_kalman_tracker: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_request && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------
    // one command transfer; valid stays high unless an idle burst follows
    task automatic send_command(logic [1:0] cmd, word_t ax, word_t ay, word_t az,
                                logic [16:0] dt, word_t mx, word_t my, word_t mz);
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_accel_x   <= ax;
        s_accel_y   <= ay;
        s_accel_z   <= az;
        s_step_time <= dt;
        s_meas_x    <= mx;
        s_meas_y    <= my;
        s_meas_z    <= mz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // register writes only when the block has gone quiet
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    function automatic word_t rand_value();
        case ($urandom_range(0, 5))
            0:       return word_t'($urandom());                     // full range
            1:       return ($urandom_range(0, 1)) ? WORD_MAX : WORD_MIN;
            default: return word_t'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000);
        endcase
    endfunction

    // mostly predicts and updates in random order, some restarts and unused codes
    task automatic random_commands(int count);
        logic [1:0]  cmd;
        logic [16:0] dt;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       cmd = CMD_RESTART;
            else if (pick < 55) cmd = CMD_PREDICT;
            else if (pick < 95) cmd = CMD_UPDATE;
            else                cmd = CMD_IDLE_CODE;
            if ($urandom_range(0, 9) == 0) dt = 17'($urandom());
            else                           dt = 17'($urandom_range(0, 65536));
            send_command(cmd, rand_value(), rand_value(), rand_value(), dt,
                         rand_value(), rand_value(), rand_value());
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        cycles       = 0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every command, field extremes, unused code, long dt
        send_command(CMD_IDLE_CODE, '0, '0, '0, '0, '0, '0, '0);
        send_command(CMD_UPDATE, '0, '0, '0, '0, ONE, -ONE, '0);
        send_command(CMD_PREDICT, WORD_MAX, WORD_MIN, '0, 17'd65536, '0, '0, '0);
        send_command(CMD_PREDICT, WORD_MIN, WORD_MAX, -1, 17'h1FFFF, '0, '0, '0);
        send_command(CMD_PREDICT, ONE, ONE, ONE, 17'd0, '0, '0, '0);
        send_command(CMD_UPDATE, '0, '0, '0, '0, WORD_MAX, WORD_MIN, -1);
        send_command(CMD_IDLE_CODE, WORD_MAX, WORD_MAX, WORD_MAX, 17'h1FFFF,
                     WORD_MAX, WORD_MAX, WORD_MAX);
        send_command(CMD_RESTART, WORD_MIN, WORD_MIN, WORD_MIN, 17'h1FFFF,
                     WORD_MIN, WORD_MIN, WORD_MIN);
        send_command(CMD_PREDICT, -ONE, HALF, QUARTER, 17'd32768, '0, '0, '0);
        send_command(CMD_UPDATE, '0, '0, '0, '0, 5 * ONE, -3 * ONE, ONE);
        send_command(CMD_PREDICT, '0, '0, '0, 17'd1, '0, '0, '0);
        send_command(CMD_UPDATE, '0, '0, '0, '0, WORD_MIN, WORD_MAX, '0);
        wait_drained();

        // zero position variance, extreme measurement noise; bad indexes ignored
        write_reg(REG_POS_VAR, 32'h0);
        write_reg(REG_MEAS_VAR, 32'hFFFF_FFFF);
        write_reg(REG_NONE_A, 32'h1234_5678);
        write_reg(REG_NONE_B, 32'hFFFF_FFFF);
        send_command(CMD_RESTART, '0, '0, '0, '0, '0, '0, '0);
        send_command(CMD_UPDATE, '0, '0, '0, '0, ONE, ONE, ONE);
        send_command(CMD_PREDICT, ONE, ONE, ONE, 17'd65536, '0, '0, '0);
        send_command(CMD_UPDATE, '0, '0, '0, '0, -ONE, WORD_MAX, WORD_MIN);
        random_commands(400);
        wait_drained();

        // maximum position variance, smallest measurement noise
        write_reg(REG_POS_VAR, 32'h7FFF_FFFF);
        write_reg(REG_MEAS_VAR, 32'h0000_0001);
        send_command(CMD_RESTART, '0, '0, '0, '0, '0, '0, '0);
        random_commands(200);
        // long receiver hold-off while commands keep coming: input must stall
        hold_request = 1'b1;
        random_commands(200);
        wait_drained();

        // typical tuning, with bit 31 of the data set to prove it is dropped
        write_reg(REG_POS_VAR, 32'h8004_0000);
        write_reg(REG_MEAS_VAR, 32'h0000_4000);
        send_command(CMD_RESTART, '0, '0, '0, '0, '0, '0, '0);
        random_commands(400);
        wait_drained();

        write_reg(REG_POS_VAR, {1'b0, 31'($urandom())});
        write_reg(REG_MEAS_VAR, {1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF))});
        random_commands(400);
        wait_drained();

        // last stretch: both sides always ready
        quiet = 1'b1;
        write_reg(REG_POS_VAR, 32'h0001_0000);
        write_reg(REG_MEAS_VAR, 32'h0001_0000);
        send_command(CMD_RESTART, '0, '0, '0, '0, '0, '0, '0);
        random_commands(300);
        wait_drained();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_position_velocity_kalman_tracker: done, clean");
        end else begin
            $display("tb_position_velocity_kalman_tracker: done, errors");
        end
        $finish;
    end

endmodule
